// ===== hw/rtl/rmpg_pkg.sv =====
// Package of the ring mesh point generator: register indexes, reset values,
// datapath widths, the sideband struct and the CORDIC arctangent table.
// Depends on nothing; rmpg_if, rmpg_cordic and the top level use it.
package rmpg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LENGTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS_AROUND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RINGS_ACROSS    = 3'd5;

    localparam logic [15:0] RST_INNER_RADIUS    = 16'd128;
    localparam logic [15:0] RST_OUTER_RADIUS    = 16'd256;
    localparam logic [15:0] RST_ANGLE_START     = 16'd0;
    localparam logic [16:0] RST_ANGLE_LENGTH    = 17'd65536;
    localparam logic [8:0]  RST_SEGMENTS_AROUND = 9'd8;
    localparam logic [8:0]  RST_RINGS_ACROSS    = 9'd1;

    localparam int DEF_MAX_SEGMENTS  = 256;
    localparam int DEF_MAX_RINGS     = 256;
    localparam int DEF_CORDIC_STAGES = 16;

    // Numerator widths of the grid dividers and of the texture dividers, then CORDIC widths.
    localparam int GRID_NUM_W = 26;
    localparam int UV_NUM_W   = 31;
    localparam int CORD_W     = 34;
    localparam int TRIG_W     = 32;

    localparam logic signed [CORD_W-1:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic        point_valid;
        logic        quad_valid;
        logic [16:0] corner_a;
        logic [16:0] corner_b;
        logic [16:0] corner_c;
        logic [16:0] corner_d;
    } t_side;

    // Arctangent of 2^-i, 2^32 units per turn.
    function automatic logic signed [CORD_W-1:0] atan_lut(input int unsigned idx);
        logic signed [CORD_W-1:0] v;
        case (idx)
            0:  v = 34'sh020000000;
            1:  v = 34'sh012E4051E;
            2:  v = 34'sh009FB385B;
            3:  v = 34'sh0051111D4;
            4:  v = 34'sh0028B0D43;
            5:  v = 34'sh00145D7E1;
            6:  v = 34'sh000A2F61E;
            7:  v = 34'sh000517C55;
            8:  v = 34'sh00028BE53;
            9:  v = 34'sh000145F2F;
            10: v = 34'sh0000A2F98;
            11: v = 34'sh0000517CC;
            12: v = 34'sh000028BE6;
            13: v = 34'sh0000145F3;
            14: v = 34'sh00000A2FA;
            15: v = 34'sh00000517D;
            16: v = 34'sh0000028BE;
            17: v = 34'sh00000145F;
            18: v = 34'sh000000A30;
            19: v = 34'sh000000518;
            20: v = 34'sh00000028C;
            21: v = 34'sh000000146;
            22: v = 34'sh0000000A3;
            23: v = 34'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/rmpg_if.sv =====
// Channel interfaces of the ring mesh point generator: grid point input,
// vertex result output and configuration write channel. Uses rmpg_pkg.
interface rmpg_in_if;
    logic       valid;
    logic       ready;
    logic [8:0] ring_row;
    logic [8:0] segment_col;
    modport source (output valid, ring_row, segment_col, input ready);
    modport sink   (input valid, ring_row, segment_col, output ready);
endinterface

interface rmpg_out_if;
    logic               valid;
    logic               ready;
    logic               point_valid;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               quad_valid;
    logic [16:0]        corner_a;
    logic [16:0]        corner_b;
    logic [16:0]        corner_c;
    logic [16:0]        corner_d;
    modport source (output valid, point_valid, pos_x, pos_y, tex_u, tex_v, quad_valid,
                    corner_a, corner_b, corner_c, corner_d, input ready);
    modport sink   (input valid, point_valid, pos_x, pos_y, tex_u, tex_v, quad_valid,
                    corner_a, corner_b, corner_c, corner_d, output ready);
endinterface

interface rmpg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rmpg_pkg::CFG_IDX_W-1:0]   index;
    logic [rmpg_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rmpg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the grid
// point generator. The divisor must be held static while items are in
// flight; the divider itself does not enforce it. Depends on nothing.
module rmpg_div #(
    parameter int NW = 26,
    parameter int DW = 9
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0] p_rem;
        logic [NW-1:0] p_num;
        logic [NW-1:0] p_quo;
        logic [DW:0]   trial;
        logic [DW:0]   diffv;
        logic          take;

        if (k == 0) begin : g_first
            assign p_rem = '0;
            assign p_num = i_num;
            assign p_quo = '0;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_num = r_num[k-1];
            assign p_quo = r_quo[k-1];
        end

        assign trial = {p_rem, p_num[NW-1]};
        assign take  = (trial >= {1'b0, i_den});
        assign diffv = trial - {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? diffv[DW-1:0] : trial[DW-1:0];
                r_num[k] <= {p_num[NW-2:0], 1'b0};
                r_quo[k] <= {p_quo[NW-2:0], take};
            end
        end
    end

    assign o_quo = r_quo[NW-1];
    assign o_rem = r_rem[NW-1];

endmodule

// ===== hw/rtl/rmpg_cordic.sv =====
// Pipelined rotation-mode CORDIC: folds a 16-bit binary angle into plus or
// minus a quarter turn, rotates over STAGES registered stages, then restores
// the sign. Uses rmpg_pkg for the gain constant and the arctangent table.
module rmpg_cordic #(
    parameter int STAGES = rmpg_pkg::DEF_CORDIC_STAGES
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [15:0]                         i_ang,
    output logic signed [rmpg_pkg::TRIG_W-1:0]  o_cos,
    output logic signed [rmpg_pkg::TRIG_W-1:0]  o_sin
);

    localparam int W = rmpg_pkg::CORD_W;

    logic signed [W-1:0] r_x [STAGES+1];
    logic signed [W-1:0] r_y [STAGES+1];
    logic signed [W-1:0] r_z [STAGES+1];
    logic                r_neg [STAGES+1];

    logic signed [17:0] zs;
    logic signed [17:0] zf;
    logic               fneg;

    // A half-turn fold flips the sign of both outputs.
    always_comb begin
        zs   = {{2{i_ang[15]}}, i_ang};
        zf   = zs;
        fneg = 1'b0;
        if (zs > 18'sd16384) begin
            zf   = zs - 18'sd32768;
            fneg = 1'b1;
        end else if (zs < -18'sd16384) begin
            zf   = zs + 18'sd32768;
            fneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= rmpg_pkg::CORDIC_X0;
            r_y[0]   <= '0;
            r_z[0]   <= {zf, 16'b0};
            r_neg[0] <= fneg;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;
        logic                pos;

        assign xs  = r_x[i] >>> i;
        assign ys  = r_y[i] >>> i;
        assign pos = ~r_z[i][W-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]   <= pos ? r_x[i] - ys : r_x[i] + ys;
                r_y[i+1]   <= pos ? r_y[i] + xs : r_y[i] - xs;
                r_z[i+1]   <= pos ? r_z[i] - rmpg_pkg::atan_lut(i)
                                  : r_z[i] + rmpg_pkg::atan_lut(i);
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    logic signed [W-1:0] nx;
    logic signed [W-1:0] ny;

    assign nx = -r_x[STAGES];
    assign ny = -r_y[STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= r_neg[STAGES] ? nx[rmpg_pkg::TRIG_W-1:0] : r_x[STAGES][rmpg_pkg::TRIG_W-1:0];
            o_sin <= r_neg[STAGES] ? ny[rmpg_pkg::TRIG_W-1:0] : r_y[STAGES][rmpg_pkg::TRIG_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/rmpg_delay.sv =====
// Payload delay line that keeps sideband fields aligned with the arithmetic
// units of the point generator. Depends on nothing.
module rmpg_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

// ===== hw/rtl/ring_mesh_point_generator.sv =====
// Top level of the ring mesh point generator: grid point to vertex pipeline.
// Uses rmpg_pkg, rmpg_if, rmpg_div, rmpg_cordic and rmpg_delay.
//
// Usage: each item on i_pt carries one grid point (ring_row, segment_col).
// Each item produces exactly one result item on o_res: the vertex position in
// Q8.8, its texture coordinates in Q1.16, the point and quad valid flags and
// the four corner indices of the quad that starts at the point.
// The configuration channel i_cfg is always ready; write it only while no
// items are in flight. Register indexes follow rmpg_pkg.
// Stages in order: one input stage, a 26-stage radius and angle divider, the
// radius and angle sum stage, the CORDIC fold register, rotation stages and
// sign register, the multiply and rounding stages, a 31-stage texture divider
// and the output register. Throughput is one item per cycle without stalls.
// The whole pipeline advances as one when the output register is empty or
// taken. When the receiver stalls with a result held, the pipeline freezes,
// i_pt.ready drops, and nothing is lost or repeated.
// Reset (synchronous, active low) clears the valid bits of every stage and
// restores the configuration registers to their documented reset values.
module ring_mesh_point_generator #(
    parameter int MAX_SEGMENTS  = rmpg_pkg::DEF_MAX_SEGMENTS,
    parameter int MAX_RINGS     = rmpg_pkg::DEF_MAX_RINGS,
    parameter int CORDIC_STAGES = rmpg_pkg::DEF_CORDIC_STAGES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmpg_in_if.sink   i_pt,
    rmpg_out_if.source o_res,
    rmpg_cfg_if.sink  i_cfg
);

    localparam int DIV_LAT  = rmpg_pkg::GRID_NUM_W;
    localparam int UV_LAT   = rmpg_pkg::UV_NUM_W;
    localparam int CORD_LAT = CORDIC_STAGES + 2;
    localparam int LAT      = DIV_LAT + CORD_LAT + UV_LAT + 5;

    // The count registers are 9 bits wide, so the clamp never exceeds 511.
    localparam int SEG_HI = (MAX_SEGMENTS > 511) ? 511 : MAX_SEGMENTS;
    localparam int RNG_HI = (MAX_RINGS > 511) ? 511 : MAX_RINGS;
    localparam logic [8:0] SEG_HI9 = 9'(SEG_HI);
    localparam logic [8:0] RNG_HI9 = 9'(RNG_HI);

    localparam int SIDE_W = $bits(rmpg_pkg::t_side);

    // Configuration registers.
    logic [15:0] r_inner;
    logic [15:0] r_outer;
    logic [15:0] r_start;
    logic [16:0] r_len;
    logic [8:0]  r_segs;
    logic [8:0]  r_rings;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= rmpg_pkg::RST_INNER_RADIUS;
            r_outer <= rmpg_pkg::RST_OUTER_RADIUS;
            r_start <= rmpg_pkg::RST_ANGLE_START;
            r_len   <= rmpg_pkg::RST_ANGLE_LENGTH;
            r_segs  <= rmpg_pkg::RST_SEGMENTS_AROUND;
            r_rings <= rmpg_pkg::RST_RINGS_ACROSS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rmpg_pkg::REG_INNER_RADIUS:    r_inner <= i_cfg.data[15:0];
                rmpg_pkg::REG_OUTER_RADIUS:    r_outer <= i_cfg.data[15:0];
                rmpg_pkg::REG_ANGLE_START:     r_start <= i_cfg.data[15:0];
                rmpg_pkg::REG_ANGLE_LENGTH:    r_len   <= i_cfg.data;
                rmpg_pkg::REG_SEGMENTS_AROUND: r_segs  <= i_cfg.data[8:0];
                rmpg_pkg::REG_RINGS_ACROSS:    r_rings <= i_cfg.data[8:0];
                default: begin
                end
            endcase
        end
    end

    // Global advance: the pipeline moves whenever the output can move.
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en         = ~r_vld[LAT-1] | o_res.ready;
    assign i_pt.ready = en;
    assign o_res.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_pt.valid};
        end
    end

    // Input stage: clamp the counts and the angle length, form both dividend
    // magnitudes, the valid flags and the quad corner indices.
    logic [8:0]          seg_c;
    logic [8:0]          rng_c;
    logic [16:0]         len_c;
    logic [16:0]         rdiff;
    logic [16:0]         rdiff_n;
    logic                rneg;
    logic [15:0]         rmag;
    logic [24:0]         rnum;
    logic [25:0]         anum;
    logic [19:0]         a_full;
    logic [19:0]         b_full;
    logic [19:0]         c_full;
    logic [19:0]         d_full;
    rmpg_pkg::t_side     side_a;

    always_comb begin
        if (r_segs < 9'd3) begin
            seg_c = 9'd3;
        end else if (r_segs > SEG_HI9) begin
            seg_c = SEG_HI9;
        end else begin
            seg_c = r_segs;
        end
        if (r_rings < 9'd1) begin
            rng_c = 9'd1;
        end else if (r_rings > RNG_HI9) begin
            rng_c = RNG_HI9;
        end else begin
            rng_c = r_rings;
        end
        len_c   = (r_len > 17'd65536) ? 17'd65536 : r_len;
        rdiff   = {1'b0, r_outer} - {1'b0, r_inner};
        rdiff_n = -rdiff;
        rneg    = rdiff[16];
        rmag    = rneg ? rdiff_n[15:0] : rdiff[15:0];
        rnum    = i_pt.ring_row * rmag;
        anum    = i_pt.segment_col * len_c;
        a_full  = i_pt.ring_row * ({1'b0, seg_c} + 10'd1) + {11'b0, i_pt.segment_col};
        b_full  = a_full + {11'b0, seg_c} + 20'd1;
        c_full  = a_full + {11'b0, seg_c} + 20'd2;
        d_full  = a_full + 20'd1;

        side_a.point_valid = (i_pt.ring_row <= rng_c) && (i_pt.segment_col <= seg_c);
        side_a.quad_valid  = (i_pt.ring_row < rng_c) && (i_pt.segment_col < seg_c);
        side_a.corner_a    = side_a.quad_valid ? a_full[16:0] : 17'd0;
        side_a.corner_b    = side_a.quad_valid ? b_full[16:0] : 17'd0;
        side_a.corner_c    = side_a.quad_valid ? c_full[16:0] : 17'd0;
        side_a.corner_d    = side_a.quad_valid ? d_full[16:0] : 17'd0;
    end

    logic [25:0]     r_a_rnum;
    logic [25:0]     r_a_anum;
    logic            r_a_neg;
    rmpg_pkg::t_side r_a_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rnum <= {1'b0, rnum};
            r_a_anum <= anum;
            r_a_neg  <= rneg;
            r_a_side <= side_a;
        end
    end

    // Radius step and angle step dividers run side by side.
    logic [25:0] rad_q;
    logic [8:0]  rad_rem;
    logic [25:0] ang_q;
    logic [8:0]  ang_rem;

    rmpg_div #(.NW(DIV_LAT), .DW(9)) u_div_rad (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_a_rnum),
        .i_den (rng_c),
        .o_quo (rad_q),
        .o_rem (rad_rem)
    );

    rmpg_div #(.NW(DIV_LAT), .DW(9)) u_div_ang (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_a_anum),
        .i_den (seg_c),
        .o_quo (ang_q),
        .o_rem (ang_rem)
    );

    logic [SIDE_W:0] d1_out;

    rmpg_delay #(.W(SIDE_W + 1), .DEPTH(DIV_LAT)) u_dly_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data ({r_a_neg, r_a_side}),
        .o_data (d1_out)
    );

    // Radius: the quotient truncates toward zero, so the sign is applied
    // to the magnitude after the division.
    logic [17:0] rq;
    logic [17:0] rq_s;

    assign rq   = {1'b0, rad_q[16:0]};
    assign rq_s = d1_out[SIDE_W] ? -rq : rq;

    logic signed [17:0] r_b_rad;
    logic [15:0]        r_b_ang;
    rmpg_pkg::t_side    r_b_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_rad  <= $signed({2'b0, r_inner} + rq_s);
            r_b_ang  <= r_start + ang_q[15:0];
            r_b_side <= d1_out[SIDE_W-1:0];
        end
    end

    logic signed [rmpg_pkg::TRIG_W-1:0] cs;
    logic signed [rmpg_pkg::TRIG_W-1:0] sn;

    rmpg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (r_b_ang),
        .o_cos (cs),
        .o_sin (sn)
    );

    logic [SIDE_W+17:0] d2_out;

    rmpg_delay #(.W(SIDE_W + 18), .DEPTH(CORD_LAT)) u_dly_cord (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data ({r_b_rad, r_b_side}),
        .o_data (d2_out)
    );

    logic signed [17:0] d2_rad;
    assign d2_rad = $signed(d2_out[SIDE_W+17:SIDE_W]);

    // Radius times cosine and sine, Q8.8 by Q2.30.
    logic signed [49:0] r_m_px;
    logic signed [49:0] r_m_py;
    rmpg_pkg::t_side    r_m_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_px   <= d2_rad * cs;
            r_m_py   <= d2_rad * sn;
            r_m_side <= d2_out[SIDE_W-1:0];
        end
    end

    // Round to Q8.8 with a floor shift and clamp to the field range.
    function automatic logic signed [16:0] round_clamp(input logic signed [49:0] p);
        logic signed [49:0] s;
        s = (p + 50'sd536870912) >>> 30;
        if (s > 50'sd65535) begin
            return 17'sd65535;
        end else if (s < -50'sd65535) begin
            return -17'sd65535;
        end
        return s[16:0];
    endfunction

    logic signed [16:0] r_p_x;
    logic signed [16:0] r_p_y;
    rmpg_pkg::t_side    r_p_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_x    <= round_clamp(r_m_px);
            r_p_y    <= round_clamp(r_m_py);
            r_p_side <= r_m_side;
        end
    end

    // Texture coordinates divide position magnitudes by the outer radius.
    logic [16:0] px_n;
    logic [16:0] py_n;
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    logic [15:0] uv_den;

    assign px_n   = -r_p_x;
    assign py_n   = -r_p_y;
    assign mag_x  = r_p_x[16] ? px_n[15:0] : r_p_x[15:0];
    assign mag_y  = r_p_y[16] ? py_n[15:0] : r_p_y[15:0];
    assign uv_den = (r_outer == 16'd0) ? 16'd1 : r_outer;

    logic [30:0] u_q;
    logic [15:0] u_rem;
    logic [30:0] v_q;
    logic [15:0] v_rem;

    rmpg_div #(.NW(UV_LAT), .DW(16)) u_div_u (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({mag_x, 15'b0}),
        .i_den (uv_den),
        .o_quo (u_q),
        .o_rem (u_rem)
    );

    rmpg_div #(.NW(UV_LAT), .DW(16)) u_div_v (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({mag_y, 15'b0}),
        .i_den (uv_den),
        .o_quo (v_q),
        .o_rem (v_rem)
    );

    logic [SIDE_W+33:0] d3_out;

    rmpg_delay #(.W(SIDE_W + 34), .DEPTH(UV_LAT)) u_dly_uv (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data ({r_p_x, r_p_y, r_p_side}),
        .o_data (d3_out)
    );

    logic [16:0]     d3_x;
    logic [16:0]     d3_y;
    rmpg_pkg::t_side d3_side;

    assign d3_x    = d3_out[SIDE_W+33:SIDE_W+17];
    assign d3_y    = d3_out[SIDE_W+16:SIDE_W];
    assign d3_side = d3_out[SIDE_W-1:0];

    // Floor division of a negative value rounds the magnitude up.
    function automatic logic [16:0] uv_fix(input logic neg, input logic [30:0] q,
                                           input logic nz);
        logic [32:0] t;
        t = neg ? (33'd32768 - {2'b0, q} - {32'b0, nz}) : (33'd32768 + {2'b0, q});
        if (t[32]) begin
            return 17'd0;
        end else if (t > 33'd65536) begin
            return 17'd65536;
        end
        return t[16:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res.point_valid <= d3_side.point_valid;
            o_res.quad_valid  <= d3_side.quad_valid;
            o_res.corner_a    <= d3_side.corner_a;
            o_res.corner_b    <= d3_side.corner_b;
            o_res.corner_c    <= d3_side.corner_c;
            o_res.corner_d    <= d3_side.corner_d;
            if (d3_side.point_valid) begin
                o_res.pos_x <= $signed(d3_x);
                o_res.pos_y <= $signed(d3_y);
                o_res.tex_u <= uv_fix(d3_x[16], u_q, |u_rem);
                o_res.tex_v <= uv_fix(d3_y[16], v_q, |v_rem);
            end else begin
                o_res.pos_x <= '0;
                o_res.pos_y <= '0;
                o_res.tex_u <= '0;
                o_res.tex_v <= '0;
            end
        end
    end

    // A stalled result freezes every stage of the pipeline.
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> $stable(r_vld))
        else $error("pipeline moved during an output stall");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.point_valid |->
            o_res.pos_x == 17'sd0 && o_res.pos_y == 17'sd0 &&
            o_res.tex_u == 17'd0 && o_res.tex_v == 17'd0 && !o_res.quad_valid)
        else $error("invalid point carries nonzero fields");

    a_quad_corners: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.quad_valid |->
            o_res.point_valid && o_res.corner_d == o_res.corner_a + 17'd1 &&
            o_res.corner_c == o_res.corner_b + 17'd1)
        else $error("quad corners inconsistent");

    a_uv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.tex_u <= 17'd65536 && o_res.tex_v <= 17'd65536)
        else $error("texture coordinate out of range");

endmodule
